FILE: hdl/tam_pkg.sv
// Shared constants and types for the tile average mosaic unit.
package tam_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_TILE_DEF  = 255;
	localparam int HEIGHT_LIMIT  = 2048;

	localparam int TILE_RESET   = 100;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int TS_REG_W   = 8;
	localparam int DIM_REG_W  = 12;
	localparam int ROW_W      = 11;
	localparam int POS_W      = 11;
	localparam int CHAN_W     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage

FILE: hdl/tam_if.sv
// Pixel and tile result channel interfaces.
interface pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	modport source (output valid, blue, green, red, input ready);
	modport sink (input valid, blue, green, red, output ready);
endinterface

interface tile_if;
	logic        valid;
	logic        ready;
	logic [10:0] tile_column;
	logic [10:0] tile_row;
	logic [7:0]  avg_blue;
	logic [7:0]  avg_green;
	logic [7:0]  avg_red;
	logic        frame_done;

	modport source (output valid, tile_column, tile_row, avg_blue, avg_green, avg_red,
		frame_done, input ready);
	modport sink (input valid, tile_column, tile_row, avg_blue, avg_green, avg_red,
		frame_done, output ready);
endinterface

FILE: hdl/tam_front.sv
// Front end: raster counters, per-column sum store and tile completion detect.
module tam_front #(
	parameter int MAX_WIDTH = tam_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TILE  = tam_pkg::MAX_TILE_DEF,
	parameter int SUM_W     = 24,
	parameter int SEG_W     = 16,
	parameter int CNT_W     = 16,
	parameter int CNTQ_W    = 3,
	parameter int JOB_W     = 111
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pixel_if.sink                           pix,
	input  logic                            cfg_we,
	input  logic [tam_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tam_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [CNTQ_W-1:0]               q_count,
	output logic                            push,
	output logic [JOB_W-1:0]                job
);
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int TW = $clog2(MAX_TILE + 1);

	logic [tam_pkg::TS_REG_W-1:0]  ts_q;
	logic [tam_pkg::DIM_REG_W-1:0] w_q;
	logic [tam_pkg::DIM_REG_W-1:0] h_q;
	logic                          restart;

	logic [CW-1:0]               col_q, tx_q;
	logic [tam_pkg::ROW_W-1:0]   row_q, ty_q;
	logic [TW-1:0]               ox_q, oy_q;
	logic [SEG_W-1:0]            seg_q [3];

	logic [TW-1:0]               ts_eff;
	logic [XW-1:0]               w_eff;
	logic [tam_pkg::DIM_REG_W-1:0] h_eff;
	logic                        row_last, frame_last, x_end, y_end, accept;
	logic [SEG_W-1:0]            seg_new [3];
	logic [7:0]                  pix_ch [3];

	logic                        emit_s1, wr_s1, oy0_s1, done_s1, fwd_s1;
	logic [CW-1:0]               tx_s1;
	logic [tam_pkg::ROW_W-1:0]   ty_s1;
	logic [CNT_W-1:0]            cnt_s1;
	logic [SEG_W-1:0]            seg_s1 [3];
	logic [3*SUM_W-1:0]          rd_s1, fwdv_s1, base, total;
	logic [3*SUM_W-1:0]          mem_q [MAX_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= tam_pkg::TS_REG_W'(tam_pkg::TILE_RESET);
			w_q  <= tam_pkg::DIM_REG_W'(tam_pkg::WIDTH_RESET);
			h_q  <= tam_pkg::DIM_REG_W'(tam_pkg::HEIGHT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				tam_pkg::REG_TILE_SIZE:    ts_q <= cfg_data[tam_pkg::TS_REG_W-1:0];
				tam_pkg::REG_IMAGE_WIDTH:  w_q  <= cfg_data;
				tam_pkg::REG_IMAGE_HEIGHT: h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == tam_pkg::REG_TILE_SIZE ||
		cfg_index == tam_pkg::REG_IMAGE_WIDTH || cfg_index == tam_pkg::REG_IMAGE_HEIGHT);

	always_comb begin
		if (ts_q == '0)
			ts_eff = TW'(1);
		else if (32'(ts_q) > MAX_TILE)
			ts_eff = TW'(MAX_TILE);
		else
			ts_eff = TW'(ts_q);
		if (w_q == '0)
			w_eff = XW'(1);
		else if (32'(w_q) > MAX_WIDTH)
			w_eff = XW'(MAX_WIDTH);
		else
			w_eff = XW'(w_q);
		if (h_q == '0)
			h_eff = tam_pkg::DIM_REG_W'(1);
		else if (32'(h_q) > tam_pkg::HEIGHT_LIMIT)
			h_eff = tam_pkg::DIM_REG_W'(tam_pkg::HEIGHT_LIMIT);
		else
			h_eff = h_q;
	end

	assign row_last   = (32'(col_q) + 1 >= 32'(w_eff));
	assign frame_last = (32'(row_q) + 1 >= 32'(h_eff));
	assign x_end      = (32'(ox_q) + 1 >= 32'(ts_eff)) || row_last;
	assign y_end      = (32'(oy_q) + 1 >= 32'(ts_eff)) || frame_last;

	assign pix.ready = (32'(q_count) + 32'(emit_s1) < tam_pkg::QUEUE_DEPTH);
	assign accept    = pix.valid && pix.ready;

	assign pix_ch[0] = pix.blue;
	assign pix_ch[1] = pix.green;
	assign pix_ch[2] = pix.red;

	always_comb begin
		for (int c = 0; c < 3; c++)
			seg_new[c] = ((ox_q == '0) ? '0 : seg_q[c]) + SEG_W'(pix_ch[c]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			tx_q  <= '0;
			ty_q  <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			tx_q  <= '0;
			ty_q  <= '0;
		end else if (accept) begin
			if (row_last) begin
				col_q <= '0;
				ox_q  <= '0;
				tx_q  <= '0;
				if (frame_last) begin
					row_q <= '0;
					oy_q  <= '0;
					ty_q  <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (32'(oy_q) + 1 >= 32'(ts_eff)) begin
						oy_q <= '0;
						ty_q <= ty_q + 1'b1;
					end else begin
						oy_q <= oy_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (x_end) begin
					ox_q <= '0;
					tx_q <= tx_q + 1'b1;
				end else begin
					ox_q <= ox_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			emit_s1 <= accept && x_end && y_end;
			wr_s1   <= accept && x_end && !y_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < 3; c++) begin
				seg_q[c]  <= seg_new[c];
				seg_s1[c] <= seg_new[c];
			end
			oy0_s1  <= (oy_q == '0);
			done_s1 <= row_last && frame_last;
			tx_s1   <= tx_q;
			ty_s1   <= ty_q;
			cnt_s1  <= CNT_W'((TW+1)'(ox_q) + 1'b1) * CNT_W'((TW+1)'(oy_q) + 1'b1);
			fwd_s1  <= wr_s1 && (tx_s1 == tx_q);
			fwdv_s1 <= total;
			rd_s1   <= mem_q[tx_q];
		end
		if (wr_s1)
			mem_q[tx_s1] <= total;
	end

	// tiles start with an empty sum on their first row
	always_comb begin
		if (oy0_s1)
			base = '0;
		else if (fwd_s1)
			base = fwdv_s1;
		else
			base = rd_s1;
		for (int c = 0; c < 3; c++)
			total[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] + SUM_W'(seg_s1[c]);
	end

	assign push = emit_s1;
	assign job  = {tam_pkg::POS_W'(tx_s1), ty_s1, done_s1, cnt_s1, total};

endmodule

FILE: hdl/tam_fifo.sv
// Small job queue between front and back ends.
module tam_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = tam_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tam_pkg::queue_ctl_t        ctl,
	input  logic [W-1:0]               din,
	output logic [W-1:0]               dout,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  buf_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl.push)
				wp_q <= wp_q + 1'b1;
			if (ctl.pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(ctl.push) - CW'(ctl.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push)
			buf_q[wp_q] <= din;
	end

	assign dout  = buf_q[rp_q];
	assign count = cnt_q;

endmodule

FILE: hdl/tam_back.sv
// Back end: per-channel restoring divide and result register.
module tam_back #(
	parameter int SUM_W = 24,
	parameter int CNT_W = 16,
	parameter int JOB_W = 111
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  logic [JOB_W-1:0] job,
	output logic             pop,
	tile_if.source           res
);
	localparam int DW = SUM_W + tam_pkg::CHAN_W;

	tam_pkg::back_state_t state_q, state_d;

	logic [DW-1:0]                  rem_q [3];
	logic [DW-1:0]                  div_q;
	logic [tam_pkg::CHAN_W-1:0]     quo_q [3];
	logic [2:0]                     step_q;
	logic [tam_pkg::POS_W-1:0]      tx_q;
	logic [tam_pkg::ROW_W-1:0]      ty_q;
	logic                           done_q;

	logic [tam_pkg::POS_W-1:0]      j_tx;
	logic [tam_pkg::ROW_W-1:0]      j_ty;
	logic                           j_done;
	logic [CNT_W-1:0]               j_cnt;
	logic [3*SUM_W-1:0]             j_sum;

	assign {j_tx, j_ty, j_done, j_cnt, j_sum} = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tam_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		res.valid = 1'b0;
		case (state_q)
			tam_pkg::BK_IDLE: begin
				if (job_valid) begin
					pop     = 1'b1;
					state_d = tam_pkg::BK_DIV;
				end
			end
			tam_pkg::BK_DIV: begin
				if (step_q == 3'd7)
					state_d = tam_pkg::BK_OUT;
			end
			tam_pkg::BK_OUT: begin
				res.valid = 1'b1;
				if (res.ready)
					state_d = tam_pkg::BK_IDLE;
			end
			default: state_d = tam_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int c = 0; c < 3; c++)
				rem_q[c] <= DW'(j_sum[c*SUM_W +: SUM_W]);
			div_q  <= DW'(j_cnt) << 7;
			step_q <= '0;
			tx_q   <= j_tx;
			ty_q   <= j_ty;
			done_q <= j_done;
		end else if (state_q == tam_pkg::BK_DIV) begin
			for (int c = 0; c < 3; c++) begin
				if (rem_q[c] >= div_q) begin
					rem_q[c] <= rem_q[c] - div_q;
					quo_q[c] <= {quo_q[c][tam_pkg::CHAN_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][tam_pkg::CHAN_W-2:0], 1'b0};
				end
			end
			div_q  <= div_q >> 1;
			step_q <= step_q + 1'b1;
		end
	end

	assign res.tile_column = tx_q;
	assign res.tile_row    = ty_q;
	assign res.avg_blue    = quo_q[0];
	assign res.avg_green   = quo_q[1];
	assign res.avg_red     = quo_q[2];
	assign res.frame_done  = done_q;

endmodule

FILE: hdl/tile_average_mosaic_unit.sv
// Top level of the tile average mosaic unit.
//  channel | dir | payload                                        | transfer
//  pixel   | in  | blue, green, red                               | valid & ready
//  tile    | out | tile_column, tile_row, avg_*, frame_done       | valid & ready
//  cfg     | in  | cfg_index, cfg_data                            | cfg_we
// One pixel per cycle unless stalled; registered sum store read, bypassed when a column repeats.
// In the back end each tile is loaded, divided in 8 steps and held as a result until taken.
// A 4 entry queue holds finished tiles; pixel ready drops when it is full,
// counting a tile about to enter.
// Reset is asynchronous; the sum store needs no clearing, a tile's first row starts at zero.
module tile_average_mosaic_unit #(
	parameter int MAX_WIDTH = tam_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TILE  = tam_pkg::MAX_TILE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pixel_if.sink                          pixel,
	tile_if.source                         tile,
	input  logic                           cfg_we,
	input  logic [tam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tam_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int SUM_W  = $clog2(MAX_TILE * MAX_TILE * 255 + 1);
	localparam int SEG_W  = $clog2(MAX_TILE * 255 + 1);
	localparam int CNT_W  = $clog2(MAX_TILE * MAX_TILE + 1);
	localparam int CNTQ_W = $clog2(tam_pkg::QUEUE_DEPTH + 1);
	localparam int JOB_W  = tam_pkg::POS_W + tam_pkg::ROW_W + 1 + CNT_W + 3 * SUM_W;

	tam_pkg::queue_ctl_t qctl;
	logic [JOB_W-1:0]    job_in, job_out;
	logic [CNTQ_W-1:0]   q_count;

	tam_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_TILE(MAX_TILE), .SUM_W(SUM_W), .SEG_W(SEG_W),
		.CNT_W(CNT_W), .CNTQ_W(CNTQ_W), .JOB_W(JOB_W)
	) u_front (
		.clk, .arst_n, .pix(pixel), .cfg_we, .cfg_index, .cfg_data,
		.q_count, .push(qctl.push), .job(job_in)
	);

	tam_fifo #(.W(JOB_W), .DEPTH(tam_pkg::QUEUE_DEPTH)) u_fifo (
		.clk, .arst_n, .ctl(qctl), .din(job_in), .dout(job_out), .count(q_count)
	);

	tam_back #(.SUM_W(SUM_W), .CNT_W(CNT_W), .JOB_W(JOB_W)) u_back (
		.clk, .arst_n, .job_valid(q_count != '0), .job(job_out),
		.pop(qctl.pop), .res(tile)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.push && !qctl.pop |-> 32'(q_count) < tam_pkg::QUEUE_DEPTH)
		else $error("tile queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> q_count != '0)
		else $error("tile queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(q_count) <= tam_pkg::QUEUE_DEPTH)
		else $error("tile queue count out of range");
`endif

endmodule

FILE: test/tile_average_mosaic_unit_test.sv
// Testbench for the tile average mosaic unit: directed and random frames, tile results checked in order.
`timescale 1ns / 1ps

module tile_average_mosaic_unit_test;

	localparam logic [tam_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct {
		logic [10:0] tile_column;
		logic [10:0] tile_row;
		logic [7:0]  avg_blue;
		logic [7:0]  avg_green;
		logic [7:0]  avg_red;
		logic        frame_done;
	} tile_avg_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tam_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tam_pkg::CFG_DATA_W-1:0] cfg_data;

	pixel_if pixel ();
	tile_if tile ();

	tile_average_mosaic_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.tile(tile),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pixel_t pending_pixels[$];
	tile_avg_t expected_tiles[$];
	int errors = 0;
	int pixels_queued = 0;
	bit quiet = 0;
	bit hold_req = 0;
	bit pixel_taken = 0;

	// mirror of the block
	int unsigned tile_size_reg, width_reg, height_reg;
	int unsigned col, row, off_x, off_y, tile_x, tile_y;
	int unsigned blue_acc[2048], green_acc[2048], red_acc[2048];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clip(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		col = 0; row = 0; off_x = 0; off_y = 0; tile_x = 0; tile_y = 0;
		foreach (blue_acc[i]) begin
			blue_acc[i] = 0; green_acc[i] = 0; red_acc[i] = 0;
		end
	endfunction

	function automatic void apply_register(logic [tam_pkg::CFG_IDX_W-1:0] idx,
			logic [tam_pkg::CFG_DATA_W-1:0] d);
		case (idx)
			tam_pkg::REG_TILE_SIZE: tile_size_reg = 32'(d[7:0]);
			tam_pkg::REG_IMAGE_WIDTH: width_reg = 32'(d);
			tam_pkg::REG_IMAGE_HEIGHT: height_reg = 32'(d);
			default: return;
		endcase
		restart_frame();
	endfunction

	function automatic void accumulate_pixel(pixel_t p);
		int unsigned ts, w, h, cnt;
		bit row_last, last_row, x_end, y_end;
		tile_avg_t t;
		ts = clip(tile_size_reg, 255);
		w = clip(width_reg, 2048);
		h = clip(height_reg, 2048);
		row_last = col + 1 >= w;
		last_row = row + 1 >= h;
		x_end = (off_x + 1 >= ts) || row_last;
		y_end = (off_y + 1 >= ts) || last_row;
		blue_acc[tile_x] += p.blue;
		green_acc[tile_x] += p.green;
		red_acc[tile_x] += p.red;
		if (x_end && y_end) begin
			cnt = (off_x + 1) * (off_y + 1);
			t.tile_column = tile_x[10:0];
			t.tile_row = tile_y[10:0];
			t.avg_blue = 8'(blue_acc[tile_x] / cnt);
			t.avg_green = 8'(green_acc[tile_x] / cnt);
			t.avg_red = 8'(red_acc[tile_x] / cnt);
			t.frame_done = row_last && last_row;
			expected_tiles.push_back(t);
			blue_acc[tile_x] = 0; green_acc[tile_x] = 0; red_acc[tile_x] = 0;
		end
		if (row_last) begin
			col = 0; off_x = 0; tile_x = 0;
			if (last_row) begin
				row = 0; off_y = 0; tile_y = 0;
			end else begin
				row++;
				if (off_y + 1 >= ts) begin
					off_y = 0; tile_y++;
				end else off_y++;
			end
		end else begin
			col++;
			if (x_end) begin
				off_x = 0; tile_x++;
			end else off_x++;
		end
	endfunction

	// sampling, prediction, checking, watchdog
	int stall_cycles = 0;
	always @(posedge clk) begin
		tile_avg_t e;
		bit moved;
		moved = 0;
		if (tile.valid && tile.ready) begin
			moved = 1;
			if (expected_tiles.size() == 0) begin
				$error("tile transfer with no tile expected");
				errors++;
			end else begin
				e = expected_tiles.pop_front();
				if (tile.tile_column !== e.tile_column) begin
					$error("tile_column exp %0d got %0d", e.tile_column, tile.tile_column); errors++;
				end
				if (tile.tile_row !== e.tile_row) begin
					$error("tile_row exp %0d got %0d", e.tile_row, tile.tile_row); errors++;
				end
				if (tile.avg_blue !== e.avg_blue) begin
					$error("avg_blue exp %0d got %0d", e.avg_blue, tile.avg_blue); errors++;
				end
				if (tile.avg_green !== e.avg_green) begin
					$error("avg_green exp %0d got %0d", e.avg_green, tile.avg_green); errors++;
				end
				if (tile.avg_red !== e.avg_red) begin
					$error("avg_red exp %0d got %0d", e.avg_red, tile.avg_red); errors++;
				end
				if (tile.frame_done !== e.frame_done) begin
					$error("frame_done exp %0d got %0d", e.frame_done, tile.frame_done); errors++;
				end
			end
		end
		pixel_taken = pixel.valid && pixel.ready;
		if (pixel_taken) begin
			moved = 1;
			accumulate_pixel('{pixel.blue, pixel.green, pixel.red});
		end
		if (cfg_we && arst_n) apply_register(cfg_index, cfg_data);
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// pixel driver
	int src_gap = 0;
	always @(negedge clk) begin
		bit was_taken;
		was_taken = pixel_taken;
		if (!arst_n) begin
			pixel.valid <= 0;
		end else begin
			if (pixel_taken) begin
				void'(pending_pixels.pop_front());
				pixel_taken = 0;
			end
			if (pixel.valid && !was_taken) begin
				// still offering the same item
			end else if (src_gap > 0) begin
				src_gap--;
				pixel.valid <= 0;
			end else if (!quiet && pending_pixels.size() > 0 && $urandom_range(0, 11) == 0) begin
				src_gap = $urandom_range(1, 18) - 1;
				pixel.valid <= 0;
			end else if (pending_pixels.size() > 0) begin
				pixel.valid <= 1;
				pixel.blue <= pending_pixels[0].blue;
				pixel.green <= pending_pixels[0].green;
				pixel.red <= pending_pixels[0].red;
			end else begin
				pixel.valid <= 0;
			end
		end
	end

	// result receiver
	int sink_gap = 0;
	int hold_left = 0;
	bit hold_done = 0;
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			tile.ready <= 0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			tile.ready <= 0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			sink_gap = $urandom_range(1, 18) - 1;
			tile.ready <= 0;
		end else begin
			tile.ready <= 1;
		end
	end

	task automatic write_register(logic [tam_pkg::CFG_IDX_W-1:0] idx,
			logic [tam_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending_pixels.size() > 0 || pixel.valid || expected_tiles.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_frame(int unsigned ts, int unsigned w, int unsigned h);
		drain();
		write_register(tam_pkg::REG_TILE_SIZE, tam_pkg::CFG_DATA_W'(ts));
		write_register(tam_pkg::REG_IMAGE_WIDTH, tam_pkg::CFG_DATA_W'(w));
		write_register(tam_pkg::REG_IMAGE_HEIGHT, tam_pkg::CFG_DATA_W'(h));
	endtask

	task automatic push_pixels(int n, bit flat = 0, logic [7:0] v = 0);
		pixel_t p;
		repeat (n) begin
			if (flat) p = '{v, v, v};
			else begin
				p.blue = $urandom_range(0, 3) == 0 ? {8{$urandom_range(0, 1) == 1}}
					: 8'($urandom_range(0, 255));
				p.green = $urandom_range(0, 3) == 0 ? {8{$urandom_range(0, 1) == 1}}
					: 8'($urandom_range(0, 255));
				p.red = $urandom_range(0, 3) == 0 ? {8{$urandom_range(0, 1) == 1}}
					: 8'($urandom_range(0, 255));
			end
			pending_pixels.push_back(p);
			pixels_queued++;
		end
	endtask

	initial begin
		int unsigned ts, w, h, n;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		pixel.valid = 0; pixel.blue = 0; pixel.green = 0; pixel.red = 0;
		tile.ready = 0;
		tile_size_reg = tam_pkg::TILE_RESET;
		width_reg = tam_pkg::WIDTH_RESET;
		height_reg = tam_pkg::HEIGHT_RESET;
		restart_frame();
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, zero sizes, tile bigger than image, oversize registers
		set_frame(1, 2, 2);
		push_pixels(2, 1, 8'hFF); push_pixels(2, 1, 8'h00);
		set_frame(0, 0, 0);
		push_pixels(2, 1, 8'hA5);
		set_frame(255, 3, 2);
		push_pixels(6, 1, 8'hFF);
		set_frame(2, 4095, 1);
		push_pixels(4);
		drain();
		write_register(REG_SPARE, 12'hFFF);
		push_pixels(2);
		set_frame(1, 1, 4095);
		push_pixels(3);
		set_frame(255, 300, 1);
		push_pixels(300);

		// long receiver hold-off with one result per pixel
		set_frame(1, 8, 8);
		hold_req = 1;
		push_pixels(64);

		while (pixels_queued < 1400) begin
			case ($urandom_range(0, 9))
				0: ts = 0;
				1: ts = 255;
				2: ts = $urandom_range(9, 40);
				default: ts = $urandom_range(1, 8);
			endcase
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 12);
			set_frame(ts, w, h);
			if ($urandom_range(0, 4) == 0)
				write_register(REG_SPARE, tam_pkg::CFG_DATA_W'($urandom));
			n = w * h * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
			if (pixels_queued > 1200) quiet = 1;
			push_pixels(n);
		end

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
